/* src/psfl_pkg.sv */
// Shared types and constants for the page swap block.
package psfl_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int NUM_PAGES  = 64;
    localparam int PAGE_CHARS = 16;

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CHAR_W  = (PAGE_CHARS > 1) ? $clog2(PAGE_CHARS) : 1;
    localparam int LEN_W   = $clog2(PAGE_CHARS + 1);
    localparam int ADDR_W  = PAGE_W + CHAR_W;
    localparam int STORE_DEPTH = NUM_PAGES * PAGE_CHARS;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam int REG_USE_LRU = 0;

    typedef struct packed {
        logic       func;
        logic [5:0] page;
        logic [7:0] letter;
    } t_in_word;

    typedef struct packed {
        logic       hit;
        logic [1:0] frame;
        logic [5:0] evicted_page;
        logic [7:0] char_out;
        logic       empty_res;
        logic       overflow;
        logic       last;
    } t_out_word;

    // Classified access handed from the frame tracker to the page store.
    typedef struct packed {
        logic              func;
        logic [PAGE_W-1:0] page;
        logic [7:0]        letter;
        logic              hit;
        logic [1:0]        frame;
        logic [5:0]        evicted_page;
    } t_cmd;

endpackage

/* src/page_swap_fifo_lru.sv */
// Top level of the demand paging block with FIFO or LRU replacement.
//
//  channel   direction  handshake          word
//  access    in         i_push / o_full    i_in  (func, page, letter)
//  result    out        o_empty / i_pop    o_out (hit .. last)
//  config    in         APB                use_lru at address 0
//
// The tracker scans one frame per cycle, then classifies the access and
// updates the frames. The store first reads the page length; on a read it
// then fetches and emits one character at a time through its single
// registered memory port. Reset restores the initial frames and clears page
// lengths. The tracker stalls on the two-entry queue, the store on o_out.
module page_swap_fifo_lru (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  psfl_pkg::t_in_word  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output psfl_pkg::t_out_word o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import psfl_pkg::*;

    logic r_use_lru;
    logic f_ready;
    logic f_valid;
    t_cmd f_cmd;
    logic q_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic b_ready;

    assign pready = 1'b1;
    assign prdata = (32'(paddr) == REG_USE_LRU) ? {31'd0, r_use_lru} : '0;
    assign o_full = !f_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_lru <= 1'b0;
        end else if (psel && penable && pwrite && 32'(paddr) == REG_USE_LRU) begin
            r_use_lru <= pwdata[0];
        end
    end

    psfl_front u_front (
        .i_clk, .i_rst_n,
        .i_use_lru(r_use_lru),
        .i_valid(i_push),
        .i_word(i_in),
        .o_ready(f_ready),
        .o_cmd_valid(f_valid),
        .o_cmd(f_cmd),
        .i_cmd_ready(q_ready)
    );

    psfl_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid),
        .i_cmd(f_cmd),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_cmd(q_cmd),
        .i_ready(b_ready)
    );

    psfl_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid),
        .i_cmd(q_cmd),
        .o_ready(b_ready),
        .o_empty,
        .o_word(o_out),
        .i_pop
    );
endmodule

/* src/psfl_front.sv */
// Frame tracker: finds the page's frame, picks a victim and stamps the frame.
module psfl_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_use_lru,
    input  logic               i_valid,
    input  psfl_pkg::t_in_word i_word,
    output logic               o_ready,
    output logic               o_cmd_valid,
    output psfl_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_ready
);
    import psfl_pkg::*;

    logic [PAGE_W-1:0]  r_page  [NUM_FRAMES];
    logic               r_touch [NUM_FRAMES];
    logic [31:0]        r_stamp [NUM_FRAMES];
    logic [31:0]        r_count;

    logic               r_busy;
    logic               r_have;
    t_in_word           r_req;
    logic [PAGE_W-1:0]  r_pg;
    logic               r_hit;
    logic [FRAME_W-1:0] r_hfr;
    logic               r_vok;
    logic [FRAME_W-1:0] r_vic;
    logic [FRAME_W-1:0] r_scan;
    logic [1:0]         r_phase;
    logic               r_out_v;
    t_cmd               r_out;

    logic [PAGE_W-1:0]  pg_in;
    logic               better;

    assign pg_in = PAGE_W'(i_word.page % NUM_PAGES);
    assign better = r_touch[r_scan] && (!r_vok || r_stamp[r_scan] < r_stamp[r_vic]);
    assign o_ready = !r_busy && !r_out_v;
    assign o_cmd_valid = r_out_v;
    assign o_cmd = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_page[i]  <= PAGE_W'(i % NUM_PAGES);
                r_touch[i] <= 1'b0;
                r_stamp[i] <= '0;
            end
            r_count <= '0;
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
            r_phase <= '0;
        end else begin
            if (r_out_v && i_cmd_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_valid && o_ready) begin
                r_busy  <= 1'b1;
                r_req   <= i_word;
                r_pg    <= pg_in;
                r_hit   <= 1'b0;
                r_hfr   <= '0;
                r_vok   <= 1'b0;
                r_vic   <= '0;
                r_scan  <= '0;
                r_phase <= 2'd0;
            end else if (r_busy && r_phase == 2'd0) begin
                // One frame per cycle: hit search and oldest-stamp search together.
                if (!r_hit && r_page[r_scan] == r_pg) begin
                    r_hit <= 1'b1;
                    r_hfr <= r_scan;
                end
                if (better) begin
                    r_vok <= 1'b1;
                    r_vic <= r_scan;
                end
                if (32'(r_scan) == NUM_FRAMES - 1) begin
                    r_phase <= 2'd1;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end else if (r_busy && r_phase == 2'd1) begin
                r_out.func   <= r_req.func;
                r_out.page   <= r_pg;
                r_out.letter <= r_req.letter;
                r_out.hit    <= r_hit;
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
                r_count <= r_count + 1'b1;
                if (r_hit) begin
                    r_out.frame        <= 2'(r_hfr);
                    r_out.evicted_page <= '0;
                    r_touch[r_hfr] <= 1'b1;
                    r_stamp[r_hfr] <= r_count;
                end else if (i_use_lru) begin
                    r_out.frame        <= 2'(r_vic);
                    r_out.evicted_page <= 6'(r_page[r_vic]);
                    r_page[r_vic]  <= r_pg;
                    r_touch[r_vic] <= 1'b1;
                    r_stamp[r_vic] <= r_count;
                end else begin
                    r_out.frame        <= 2'(NUM_FRAMES - 1);
                    r_out.evicted_page <= 6'(r_page[0]);
                    for (int i = 0; i + 1 < NUM_FRAMES; i++) begin
                        r_page[i]  <= r_page[i+1];
                        r_touch[i] <= r_touch[i+1];
                        r_stamp[i] <= r_stamp[i+1];
                    end
                    r_page[NUM_FRAMES-1]  <= r_pg;
                    r_touch[NUM_FRAMES-1] <= 1'b1;
                    r_stamp[NUM_FRAMES-1] <= r_count;
                end
            end
        end
    end
endmodule

/* src/psfl_queue.sv */
// Two-entry queue of classified accesses between the tracker and the store.
module psfl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  psfl_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output psfl_pkg::t_cmd o_cmd,
    input  logic           i_ready
);
    import psfl_pkg::*;

    t_cmd        r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* src/psfl_back.sv */
// Page store: appends letters and streams page contents as result words.
module psfl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  psfl_pkg::t_cmd      i_cmd,
    output logic                o_ready,
    output logic                o_empty,
    output psfl_pkg::t_out_word o_word,
    input  logic                i_pop
);
    import psfl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state               r_state;
    t_cmd                 r_cmd;
    logic [LEN_W-1:0]     r_lens [NUM_PAGES];
    logic [NUM_PAGES-1:0] r_lvalid;
    logic [7:0]           r_chars [STORE_DEPTH];
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_idx;
    logic [7:0]           r_rdata;
    logic                 r_full;
    t_out_word            r_out;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 wr_en;
    logic                 can_emit;
    logic                 emit;

    assign o_ready = r_state == ST_IDLE;
    assign o_empty = !r_full;
    assign o_word = r_out;
    assign rd_en = r_state == ST_RD;
    assign rd_addr = {r_cmd.page, r_idx[CHAR_W-1:0]};
    assign wr_addr = {r_cmd.page, r_len[CHAR_W-1:0]};
    assign can_emit = !r_full || i_pop;
    assign emit = can_emit && (r_state == ST_OUT
                  || (r_state == ST_LEN && (r_cmd.func == FUNC_WRITE || r_len == '0)));
    assign wr_en = r_state == ST_LEN && r_cmd.func == FUNC_WRITE
                   && 32'(r_len) < PAGE_CHARS && can_emit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_chars[wr_addr] <= r_cmd.letter;
            r_lens[r_cmd.page] <= r_len + 1'b1;
        end
        if (rd_en) begin
            r_rdata <= r_chars[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_full   <= 1'b0;
            r_lvalid <= '0;
        end else begin
            if (emit) begin
                r_full <= 1'b1;
                r_out.hit          <= r_cmd.hit;
                r_out.frame        <= r_cmd.frame;
                r_out.evicted_page <= r_cmd.evicted_page;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
            if (wr_en) begin
                r_lvalid[r_cmd.page] <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_len   <= r_lvalid[i_cmd.page] ? r_lens[i_cmd.page] : '0;
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    r_idx <= '0;
                    if (r_cmd.func == FUNC_WRITE) begin
                        if (can_emit) begin
                            r_out.char_out  <= '0;
                            r_out.empty_res <= 1'b0;
                            r_out.overflow  <= !(32'(r_len) < PAGE_CHARS);
                            r_out.last      <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end else if (r_len == '0) begin
                        if (can_emit) begin
                            r_out.char_out  <= '0;
                            r_out.empty_res <= 1'b1;
                            r_out.overflow  <= 1'b0;
                            r_out.last      <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (can_emit) begin
                        r_out.char_out  <= r_rdata;
                        r_out.empty_res <= 1'b0;
                        r_out.overflow  <= 1'b0;
                        r_out.last      <= (r_idx + 1'b1) == r_len;
                        r_idx <= r_idx + 1'b1;
                        r_state <= ((r_idx + 1'b1) == r_len) ? ST_IDLE : ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
